// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the checker files of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge out of reset.
`define A_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define A_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define A_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/c8alu_pkg.sv =====
// Package: operation codes, flag layout, constants and word types of the 8-bit ALU.
`default_nettype none

package c8alu_pkg;

    localparam int OP_W   = 5;
    localparam int DATA_W = 16;
    localparam int BIT_W  = 3;
    localparam int FLAG_W = 4;

    // Flag bit positions.
    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    // Decimal adjust constants.
    localparam logic [7:0] DAA_HI_ADJ   = 8'h60;
    localparam logic [7:0] DAA_LO_ADJ   = 8'h06;
    localparam logic [7:0] DAA_HI_LIMIT = 8'h99;
    localparam logic [3:0] DAA_LO_LIMIT = 4'h9;

    typedef enum logic [OP_W-1:0] {
        OP_ADD     = 5'd0,
        OP_ADC     = 5'd1,
        OP_SUB     = 5'd2,
        OP_SBC     = 5'd3,
        OP_CP      = 5'd4,
        OP_INC     = 5'd5,
        OP_DEC     = 5'd6,
        OP_DAA     = 5'd7,
        OP_RLCA    = 5'd8,
        OP_RRCA    = 5'd9,
        OP_RLA     = 5'd10,
        OP_RRA     = 5'd11,
        OP_RLC     = 5'd12,
        OP_RRC     = 5'd13,
        OP_RL      = 5'd14,
        OP_RR      = 5'd15,
        OP_SLA     = 5'd16,
        OP_SRA     = 5'd17,
        OP_SWAP    = 5'd18,
        OP_SRL     = 5'd19,
        OP_BIT     = 5'd20,
        OP_RES     = 5'd21,
        OP_SET     = 5'd22,
        OP_ADD16   = 5'd23,
        OP_ADD_SPO = 5'd24
    } op_t;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [DATA_W-1:0] first_operand;
        logic [DATA_W-1:0] second_operand;
        logic [BIT_W-1:0]  bit_index;
        logic [FLAG_W-1:0] flags_in;
    } alu_req_t;

    typedef struct packed {
        logic [DATA_W-1:0] result_value;
        logic [FLAG_W-1:0] flags_out;
    } alu_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/c8alu_if.sv =====
// Interfaces: request and response channels of the 8-bit ALU.
`default_nettype none

interface c8alu_in_if;
    import c8alu_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [DATA_W-1:0] first_operand;
    logic [DATA_W-1:0] second_operand;
    logic [BIT_W-1:0]  bit_index;
    logic [FLAG_W-1:0] flags_in;

    modport source (
        output valid, operation, first_operand, second_operand, bit_index, flags_in,
        input  ready
    );

    modport sink (
        input  valid, operation, first_operand, second_operand, bit_index, flags_in,
        output ready
    );
endinterface

interface c8alu_out_if;
    import c8alu_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] result_value;
    logic [FLAG_W-1:0] flags_out;

    modport source (
        output valid, result_value, flags_out,
        input  ready
    );

    modport sink (
        input  valid, result_value, flags_out,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/c8alu_core.sv =====
// Combinational ALU datapath: one operation word in, result and flags out.
`default_nettype none

module c8alu_core (
    input  c8alu_pkg::alu_req_t req_word,
    output c8alu_pkg::alu_rsp_t rsp_word
);
    import c8alu_pkg::*;

    logic [7:0]  a;
    logic [7:0]  b;
    logic        cin;
    logic [15:0] x;
    logic [15:0] y;
    logic [3:0]  fi;

    logic [8:0]  add_sum;
    logic [4:0]  add_half;
    logic [8:0]  sub_diff;
    logic [4:0]  sub_half;
    logic        use_cin;

    logic [7:0]  inc_val;
    logic [7:0]  dec_val;

    logic        daa_hi;
    logic        daa_lo;
    logic [7:0]  daa_val;
    logic        daa_c;

    logic [7:0]  bit_mask;

    logic [16:0] w_sum;
    logic [12:0] w_half;
    logic [8:0]  spo_low;
    logic [4:0]  spo_half;
    logic [15:0] spo_sum;

    logic [7:0]  sh_val;
    logic        sh_co;

    logic [15:0] r;
    logic [3:0]  f;

    assign x   = req_word.first_operand;
    assign y   = req_word.second_operand;
    assign a   = x[7:0];
    assign b   = y[7:0];
    assign fi  = req_word.flags_in;
    assign cin = fi[FLAG_C];

    always_comb
    begin
        // Carry enters the add and subtract only for the with-carry forms.
        use_cin  = ((op_t'(req_word.operation) == OP_ADC) ||
                    (op_t'(req_word.operation) == OP_SBC)) ? cin : 1'b0;
        add_sum  = {1'b0, a} + {1'b0, b} + {8'd0, use_cin};
        add_half = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, use_cin};
        sub_diff = {1'b0, a} - {1'b0, b} - {8'd0, use_cin};
        sub_half = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, use_cin};

        inc_val = a + 8'd1;
        dec_val = a - 8'd1;

        // The high correction leaves the low nibble alone, so test it on the input.
        if (fi[FLAG_N])
        begin
            daa_hi  = 1'b0;
            daa_lo  = 1'b0;
            daa_val = a - (fi[FLAG_C] ? DAA_HI_ADJ : 8'd0) - (fi[FLAG_H] ? DAA_LO_ADJ : 8'd0);
            daa_c   = fi[FLAG_C];
        end
        else
        begin
            daa_hi  = fi[FLAG_C] || (a > DAA_HI_LIMIT);
            daa_lo  = fi[FLAG_H] || (a[3:0] > DAA_LO_LIMIT);
            daa_val = a + (daa_hi ? DAA_HI_ADJ : 8'd0) + (daa_lo ? DAA_LO_ADJ : 8'd0);
            daa_c   = daa_hi;
        end

        bit_mask = 8'd1 << req_word.bit_index;

        w_sum    = {1'b0, x} + {1'b0, y};
        w_half   = {1'b0, x[11:0]} + {1'b0, y[11:0]};
        spo_low  = {1'b0, x[7:0]} + {1'b0, b};
        spo_half = {1'b0, x[3:0]} + {1'b0, b[3:0]};
        spo_sum  = x + {{8{b[7]}}, b};

        case (op_t'(req_word.operation))
            OP_RLC:  begin sh_val = {b[6:0], b[7]};   sh_co = b[7]; end
            OP_RRC:  begin sh_val = {b[0], b[7:1]};   sh_co = b[0]; end
            OP_RL:   begin sh_val = {b[6:0], cin};    sh_co = b[7]; end
            OP_RR:   begin sh_val = {cin, b[7:1]};    sh_co = b[0]; end
            OP_SLA:  begin sh_val = {b[6:0], 1'b0};   sh_co = b[7]; end
            OP_SRA:  begin sh_val = {b[7], b[7:1]};   sh_co = b[0]; end
            OP_SWAP: begin sh_val = {b[3:0], b[7:4]}; sh_co = 1'b0; end
            default: begin sh_val = {1'b0, b[7:1]};   sh_co = b[0]; end
        endcase

        r = x;
        f = fi;
        unique case (op_t'(req_word.operation))
            OP_ADD, OP_ADC:
            begin
                r = {8'd0, add_sum[7:0]};
                f = {add_sum[7:0] == 8'd0, 1'b0, add_half[4], add_sum[8]};
            end
            OP_SUB, OP_SBC:
            begin
                r = {8'd0, sub_diff[7:0]};
                f = {sub_diff[7:0] == 8'd0, 1'b1, sub_half[4], sub_diff[8]};
            end
            OP_CP:
            begin
                f = {sub_diff[7:0] == 8'd0, 1'b1, sub_half[4], sub_diff[8]};
            end
            OP_INC:
            begin
                r = {8'd0, inc_val};
                f = {inc_val == 8'd0, 1'b0, a[3:0] == 4'hF, fi[FLAG_C]};
            end
            OP_DEC:
            begin
                r = {8'd0, dec_val};
                f = {dec_val == 8'd0, 1'b1, a[3:0] == 4'h0, fi[FLAG_C]};
            end
            OP_DAA:
            begin
                r = {8'd0, daa_val};
                f = {daa_val == 8'd0, fi[FLAG_N], 1'b0, daa_c};
            end
            OP_RLCA:
            begin
                r = {8'd0, a[6:0], a[7]};
                f = {3'b000, a[7]};
            end
            OP_RRCA:
            begin
                r = {8'd0, a[0], a[7:1]};
                f = {3'b000, a[0]};
            end
            OP_RLA:
            begin
                r = {8'd0, a[6:0], cin};
                f = {3'b000, a[7]};
            end
            OP_RRA:
            begin
                r = {8'd0, cin, a[7:1]};
                f = {3'b000, a[0]};
            end
            OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SWAP, OP_SRL:
            begin
                r = {8'd0, sh_val};
                f = {sh_val == 8'd0, 2'b00, sh_co};
            end
            OP_BIT:
            begin
                f = {(b & bit_mask) == 8'd0, 1'b0, 1'b1, fi[FLAG_C]};
            end
            OP_RES:
            begin
                r = {8'd0, b & ~bit_mask};
            end
            OP_SET:
            begin
                r = {8'd0, b | bit_mask};
            end
            OP_ADD16:
            begin
                r = w_sum[15:0];
                f = {fi[FLAG_Z], 1'b0, w_half[12], w_sum[16]};
            end
            OP_ADD_SPO:
            begin
                r = spo_sum;
                f = {2'b00, spo_half[4], spo_low[8]};
            end
            default:
            begin
                // Unassigned codes pass operand and flags through.
                r = x;
                f = fi;
            end
        endcase

        rsp_word.result_value = r;
        rsp_word.flags_out    = f;
    end

endmodule

`default_nettype wire

// ===== rtl/core/cpu8_alu_with_flags.sv =====
// Top level: 8-bit ALU with Z/N/H/C flags between an input and a result register.
//
//   channel | dir | payload                                          | handshake
//   --------+-----+--------------------------------------------------+-----------
//   req     | in  | operation, first/second_operand, bit_index, flags | valid/ready
//   rsp     | out | result_value, flags_out                          | valid/ready
//
// One word per cycle is accepted while rsp does not stall; a word passes from the input
// register through the ALU logic to the result register, which holds it while rsp stalls.
// Reset (rst_n low, asynchronous) empties both registers; nothing else needs clearing.
// While rsp stalls, req stays ready until the input register also holds a word.
`default_nettype none

module cpu8_alu_with_flags (
    input  wire         clk,
    input  wire         rst_n,
    c8alu_in_if.sink    req,
    c8alu_out_if.source rsp
);
    import c8alu_pkg::*;

    logic     stage_valid_reg;
    logic     stage_valid_next;
    alu_req_t stage_word_reg;
    logic     out_valid_reg;
    logic     out_valid_next;
    alu_rsp_t out_word_reg;
    alu_rsp_t alu_word;
    logic     out_free;
    logic     req_fire;
    logic     out_load;

    c8alu_core u_core (
        .req_word (stage_word_reg),
        .rsp_word (alu_word)
    );

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = !stage_valid_reg || out_free;
    assign req_fire  = req.valid && req.ready;
    assign out_load  = out_free && stage_valid_reg;

    always_comb
    begin
        stage_valid_next = req_fire || (stage_valid_reg && !out_free);
        out_valid_next   = out_free ? stage_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            stage_word_reg.operation      <= req.operation;
            stage_word_reg.first_operand  <= req.first_operand;
            stage_word_reg.second_operand <= req.second_operand;
            stage_word_reg.bit_index      <= req.bit_index;
            stage_word_reg.flags_in       <= req.flags_in;
        end
        if (out_load)
        begin
            out_word_reg <= alu_word;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.result_value = out_word_reg.result_value;
    assign rsp.flags_out    = out_word_reg.flags_out;

endmodule

`default_nettype wire

// ===== rtl/core/c8alu_checker.sv =====
// Checker on the top-level ports of the ALU, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module c8alu_checker (
    input wire                      clk,
    input wire                      rst_n,
    input wire                      req_valid,
    input wire                      req_ready,
    input wire                      rsp_valid,
    input wire                      rsp_ready,
    input wire [c8alu_pkg::DATA_W-1:0] rsp_result_value,
    input wire [c8alu_pkg::FLAG_W-1:0] rsp_flags_out
);
    import c8alu_pkg::*;

    logic       req_acc;
    logic       rsp_acc;
    logic       rsp_stall;
    logic       lone_stall;
    logic       out_free;
    logic [DATA_W+FLAG_W-1:0] rsp_word;
    logic [1:0] inflight_reg;
    logic [1:0] inflight_next;

    assign req_acc    = req_valid && req_ready;
    assign rsp_acc    = rsp_valid && rsp_ready;
    assign rsp_stall  = rsp_valid && !rsp_ready;
    assign lone_stall = rsp_stall && (inflight_reg == 2'd1);
    assign out_free   = !rsp_valid || rsp_ready;
    assign rsp_word   = {rsp_result_value, rsp_flags_out};

    always_comb
    begin
        inflight_next = inflight_reg + {1'b0, req_acc} - {1'b0, rsp_acc};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= 2'd0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    // Two registers hold at most two words.
    `A_ALWAYS(a_inflight_max, inflight_reg != 2'd3, "more than two words in flight")
    // A result is shown only for a word that was taken.
    `A_SAME(a_no_phantom, rsp_valid, inflight_reg != 2'd0, "result with no word in flight")
    // The input register keeps taking words while a single result waits.
    `A_SAME(a_skid_ready, lone_stall, req_ready, "input stalled behind a lone waiting result")
    // A taken word reaches the output once the output has room.
    `A_NEXT(a_latency, req_acc ##1 out_free, rsp_valid, "word did not reach the output")
    // Hold a stalled result.
    `A_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_word), "stalled result changed")

endmodule

bind cpu8_alu_with_flags c8alu_checker u_c8alu_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_result_value (rsp.result_value),
    .rsp_flags_out    (rsp.flags_out)
);

`default_nettype wire

// ===== dv/tb_cpu8_alu_with_flags.sv =====
// Testbench for the 8-bit ALU with flags: random and directed words checked against a predictor.
`timescale 1ns / 100ps
`default_nettype none

module tb_cpu8_alu_with_flags;
    import c8alu_pkg::*;

    localparam int RANDOM_WORDS = 950;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;

    logic clk;
    logic rst_n;

    c8alu_in_if  req_if ();
    c8alu_out_if rsp_if ();

    cpu8_alu_with_flags i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    alu_req_t pending_words[$];
    int       pending_gaps[$];
    alu_rsp_t expected_results[$];
    int       total_words;
    int       accepted_words = 0;
    int       error_count = 0;
    int       cycle_count = 0;
    int       gap_mode;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Expected value and flags for one request word.
    function automatic alu_rsp_t compute_alu(alu_req_t w);
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  t;
        logic        cin;
        logic        cx;
        logic        co;
        logic [8:0]  s9;
        logic [4:0]  s5;
        logic [16:0] s17;
        logic [12:0] s13;
        logic [15:0] r;
        logic [3:0]  f;
        alu_rsp_t    o;
        a   = w.first_operand[7:0];
        b   = w.second_operand[7:0];
        cin = w.flags_in[FLAG_C];
        cx  = 1'b0;
        co  = 1'b0;
        r   = w.first_operand;
        f   = w.flags_in;
        case (w.operation)
            OP_ADD, OP_ADC:
            begin
                if (w.operation == OP_ADC)
                    cx = cin;
                s9 = {1'b0, a} + {1'b0, b} + {8'b0, cx};
                s5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'b0, cx};
                r = {8'h00, s9[7:0]};
                f = '0;
                f[FLAG_Z] = (s9[7:0] == 8'h00);
                f[FLAG_H] = s5[4];
                f[FLAG_C] = s9[8];
            end
            OP_SUB, OP_SBC, OP_CP:
            begin
                if (w.operation == OP_SBC)
                    cx = cin;
                // bit 8 and bit 4 of the widened differences are the borrows
                s9 = {1'b0, a} - {1'b0, b} - {8'b0, cx};
                s5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'b0, cx};
                if (w.operation != OP_CP)
                    r = {8'h00, s9[7:0]};
                f = '0;
                f[FLAG_Z] = (s9[7:0] == 8'h00);
                f[FLAG_N] = 1'b1;
                f[FLAG_H] = s5[4];
                f[FLAG_C] = s9[8];
            end
            OP_INC:
            begin
                t = a + 8'h01;
                r = {8'h00, t};
                f[FLAG_Z] = (t == 8'h00);
                f[FLAG_N] = 1'b0;
                f[FLAG_H] = (a[3:0] == 4'hF);
            end
            OP_DEC:
            begin
                t = a - 8'h01;
                r = {8'h00, t};
                f[FLAG_Z] = (t == 8'h00);
                f[FLAG_N] = 1'b1;
                f[FLAG_H] = (a[3:0] == 4'h0);
            end
            OP_DAA:
            begin
                t = a;
                f[FLAG_H] = 1'b0;
                if (w.flags_in[FLAG_N])
                begin
                    if (w.flags_in[FLAG_C])
                        t = t - DAA_HI_ADJ;
                    if (w.flags_in[FLAG_H])
                        t = t - DAA_LO_ADJ;
                end
                else
                begin
                    if (w.flags_in[FLAG_C] || t > DAA_HI_LIMIT)
                    begin
                        t = t + DAA_HI_ADJ;
                        f[FLAG_C] = 1'b1;
                    end
                    if (w.flags_in[FLAG_H] || t[3:0] > DAA_LO_LIMIT)
                        t = t + DAA_LO_ADJ;
                end
                r = {8'h00, t};
                f[FLAG_Z] = (t == 8'h00);
            end
            OP_RLCA, OP_RRCA, OP_RLA, OP_RRA:
            begin
                case (w.operation)
                    OP_RLCA: begin co = a[7]; t = {a[6:0], a[7]}; end
                    OP_RRCA: begin co = a[0]; t = {a[0], a[7:1]}; end
                    OP_RLA:  begin co = a[7]; t = {a[6:0], cin}; end
                    default: begin co = a[0]; t = {cin, a[7:1]}; end
                endcase
                r = {8'h00, t};
                f = '0;
                f[FLAG_C] = co;
            end
            OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SWAP, OP_SRL:
            begin
                case (w.operation)
                    OP_RLC:  begin co = b[7]; t = {b[6:0], b[7]}; end
                    OP_RRC:  begin co = b[0]; t = {b[0], b[7:1]}; end
                    OP_RL:   begin co = b[7]; t = {b[6:0], cin}; end
                    OP_RR:   begin co = b[0]; t = {cin, b[7:1]}; end
                    OP_SLA:  begin co = b[7]; t = {b[6:0], 1'b0}; end
                    OP_SRA:  begin co = b[0]; t = {b[7], b[7:1]}; end
                    OP_SWAP: begin co = 1'b0; t = {b[3:0], b[7:4]}; end
                    default: begin co = b[0]; t = {1'b0, b[7:1]}; end
                endcase
                r = {8'h00, t};
                f = '0;
                f[FLAG_Z] = (t == 8'h00);
                f[FLAG_C] = co;
            end
            OP_BIT:
            begin
                f[FLAG_Z] = ~b[w.bit_index];
                f[FLAG_N] = 1'b0;
                f[FLAG_H] = 1'b1;
            end
            OP_RES:
            begin
                t = b;
                t[w.bit_index] = 1'b0;
                r = {8'h00, t};
            end
            OP_SET:
            begin
                t = b;
                t[w.bit_index] = 1'b1;
                r = {8'h00, t};
            end
            OP_ADD16:
            begin
                s17 = {1'b0, w.first_operand} + {1'b0, w.second_operand};
                s13 = {1'b0, w.first_operand[11:0]} + {1'b0, w.second_operand[11:0]};
                r = s17[15:0];
                f[FLAG_N] = 1'b0;
                f[FLAG_H] = s13[12];
                f[FLAG_C] = s17[16];
            end
            OP_ADD_SPO:
            begin
                // carries come from the unsigned low-byte add
                s5 = {1'b0, w.first_operand[3:0]} + {1'b0, b[3:0]};
                s9 = {1'b0, w.first_operand[7:0]} + {1'b0, b};
                r = w.first_operand + {{8{b[7]}}, b};
                f = '0;
                f[FLAG_H] = s5[4];
                f[FLAG_C] = s9[8];
            end
            default:
            begin
                r = w.first_operand;
                f = w.flags_in;
            end
        endcase
        o.result_value = r;
        o.flags_out    = f;
        return o;
    endfunction

    function automatic int draw_wait(int mode);
        case (mode)
            0:       return 0;
            1:       return $urandom_range(0, 19);
            default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
        endcase
    endfunction

    // Operand with a bias toward carry, borrow and decimal corners.
    function automatic logic [15:0] pick_operand();
        logic [15:0] v;
        v = 16'($urandom);
        case ($urandom_range(0, 4))
            0:
            begin
                case ($urandom_range(0, 7))
                    0: v[7:0] = 8'h00;
                    1: v[7:0] = 8'hFF;
                    2: v[7:0] = 8'h0F;
                    3: v[7:0] = 8'h10;
                    4: v[7:0] = 8'h7F;
                    5: v[7:0] = 8'h80;
                    6: v[7:0] = 8'h99;
                    default: v[7:0] = 8'h01;
                endcase
            end
            1:
            begin
                case ($urandom_range(0, 4))
                    0: v = 16'h0000;
                    1: v = 16'hFFFF;
                    2: v = 16'h0FFF;
                    3: v = 16'h8000;
                    default: v = 16'hF000;
                endcase
            end
            2: v[7:0] = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
            default: ;
        endcase
        return v;
    endfunction

    task automatic queue_word(input logic [4:0] op, input logic [15:0] x,
                              input logic [15:0] y, input logic [2:0] bi,
                              input logic [3:0] fl);
        alu_req_t w;
        w.operation      = op;
        w.first_operand  = x;
        w.second_operand = y;
        w.bit_index      = bi;
        w.flags_in       = fl;
        pending_words.push_back(w);
        pending_gaps.push_back(draw_wait(gap_mode));
    endtask

    // Request driver: one word per slot, idle gaps of random length, possibly none, between words.
    alu_req_t drive_word;
    int       drive_wait;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_if.valid          <= 1'b0;
            req_if.operation      <= '0;
            req_if.first_operand  <= '0;
            req_if.second_operand <= '0;
            req_if.bit_index      <= '0;
            req_if.flags_in       <= '0;
            drive_wait            <= 0;
        end
        else
        begin
            if (req_if.valid && req_if.ready)
            begin
                expected_results.push_back(compute_alu(drive_word));
                accepted_words++;
            end
            if (!req_if.valid || req_if.ready)
            begin
                if (drive_wait > 0)
                begin
                    req_if.valid <= 1'b0;
                    drive_wait   <= drive_wait - 1;
                end
                else if (pending_words.size() > 0)
                begin
                    drive_word = pending_words.pop_front();
                    req_if.operation      <= drive_word.operation;
                    req_if.first_operand  <= drive_word.first_operand;
                    req_if.second_operand <= drive_word.second_operand;
                    req_if.bit_index      <= drive_word.bit_index;
                    req_if.flags_in       <= drive_word.flags_in;
                    req_if.valid          <= 1'b1;
                    drive_wait            <= pending_gaps.pop_front();
                end
                else
                begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Response monitor: check each word, stall at random.
    int       stall_left;
    int       ready_mode;
    int       results_seen;
    alu_rsp_t want;
    int       next_stall;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            stall_left   <= 0;
            ready_mode   <= 0;
            results_seen <= 0;
        end
        else if (rsp_if.valid && rsp_if.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: result_value %h flags_out %h",
                       rsp_if.result_value, rsp_if.flags_out);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (rsp_if.result_value !== want.result_value)
                begin
                    $error("result_value mismatch: expected %h, actual %h",
                           want.result_value, rsp_if.result_value);
                    error_count++;
                end
                if (rsp_if.flags_out !== want.flags_out)
                begin
                    $error("flags_out mismatch: expected %h, actual %h",
                           want.flags_out, rsp_if.flags_out);
                    error_count++;
                end
            end
            results_seen <= results_seen + 1;
            if (results_seen % 80 == 79)
                ready_mode <= $urandom_range(0, 2);
            next_stall = draw_wait(ready_mode);
            if (next_stall > 0)
            begin
                rsp_if.ready <= 1'b0;
                stall_left   <= next_stall - 1;
            end
            else
            begin
                rsp_if.ready <= 1'b1;
            end
        end
        else if (stall_left > 0)
        begin
            rsp_if.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end
        else
        begin
            rsp_if.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        logic [4:0] op;
        rst_n                 = 1'b0;
        gap_mode              = 0;

        // directed corners
        queue_word(OP_ADD,     16'hFF00, 16'h0001, 3'd0, 4'h0);
        queue_word(OP_ADD,     16'h00FF, 16'hFF01, 3'd0, 4'hF);
        queue_word(OP_ADC,     16'h00FF, 16'h0000, 3'd0, 4'h1);
        queue_word(OP_SUB,     16'h0010, 16'h0001, 3'd0, 4'h0);
        queue_word(OP_SBC,     16'h0000, 16'h00FF, 3'd0, 4'h1);
        queue_word(OP_CP,      16'hAB12, 16'hFF12, 3'd0, 4'h0);
        queue_word(OP_INC,     16'hFFFF, 16'h0000, 3'd0, 4'h1);
        queue_word(OP_DEC,     16'h0001, 16'hFFFF, 3'd0, 4'h0);
        queue_word(OP_DAA,     16'h009A, 16'h0000, 3'd0, 4'h0);
        queue_word(OP_DAA,     16'h00FA, 16'h0000, 3'd0, 4'h3);
        queue_word(OP_DAA,     16'h0000, 16'h0000, 3'd0, 4'h7);
        queue_word(OP_RLCA,    16'h0080, 16'h0000, 3'd0, 4'h8);
        queue_word(OP_RRCA,    16'h0001, 16'h0000, 3'd0, 4'h0);
        queue_word(OP_RLA,     16'h0080, 16'h0000, 3'd0, 4'h1);
        queue_word(OP_RRA,     16'h0001, 16'h0000, 3'd0, 4'h1);
        queue_word(OP_RLC,     16'h0000, 16'hFF80, 3'd0, 4'h0);
        queue_word(OP_RRC,     16'h0000, 16'h0001, 3'd0, 4'hF);
        queue_word(OP_RL,      16'h0000, 16'h0080, 3'd0, 4'h0);
        queue_word(OP_RR,      16'h0000, 16'h0001, 3'd0, 4'h1);
        queue_word(OP_SLA,     16'h0000, 16'h0080, 3'd0, 4'h0);
        queue_word(OP_SRA,     16'h0000, 16'h0081, 3'd0, 4'h0);
        queue_word(OP_SWAP,    16'h0000, 16'hAB00, 3'd0, 4'hF);
        queue_word(OP_SRL,     16'h0000, 16'h0001, 3'd0, 4'h0);
        queue_word(OP_BIT,     16'h1234, 16'h007F, 3'd7, 4'h1);
        queue_word(OP_RES,     16'h0000, 16'hFFFF, 3'd7, 4'hA);
        queue_word(OP_SET,     16'h0000, 16'h0000, 3'd0, 4'h5);
        queue_word(OP_ADD16,   16'hFFFF, 16'h0001, 3'd0, 4'hF);
        queue_word(OP_ADD_SPO, 16'h00FF, 16'hFF80, 3'd0, 4'hF);
        queue_word(5'd31,      16'hFFFF, 16'hFFFF, 3'd7, 4'hF);

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i % 100 == 0)
                gap_mode = $urandom_range(0, 2);
            if ($urandom_range(0, 15) == 0)
                op = 5'($urandom_range(OP_ADD_SPO + 1, 31));
            else
                op = 5'($urandom_range(OP_ADD, OP_ADD_SPO));
            queue_word(op, pick_operand(), pick_operand(), 3'($urandom_range(0, 7)),
                       4'($urandom_range(0, 15)));
        end
        total_words = pending_words.size();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_words != total_words)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+rtl/core
rtl/core/c8alu_pkg.sv
rtl/core/c8alu_if.sv
rtl/core/c8alu_core.sv
rtl/core/cpu8_alu_with_flags.sv
rtl/core/c8alu_checker.sv
dv/tb_cpu8_alu_with_flags.sv
